// ===== rtl/bu2x_pkg.sv =====
// Shared types and constants for the 2x bilinear upsampler.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package bu2x_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int DIM_BITS    = 12;
  localparam int PLANE_BITS  = 16;
  localparam int COORD_BITS  = 12;
  localparam int SUM_BITS    = SAMPLE_BITS + 6;

  localparam int JOBQ_DEPTH    = 4;
  localparam int JOBQ_PTR_BITS = $clog2(JOBQ_DEPTH);

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PLANE_COUNT  = 2'd2;

  // Position of an output row or column relative to twice the source index.
  localparam logic [1:0] PHASE_BEFORE = 2'd0;
  localparam logic [1:0] PHASE_AT     = 2'd1;
  localparam logic [1:0] PHASE_AFTER  = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t             cur;
    sample_t             left;
    sample_t             up;
    sample_t             up_left;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                row_nz;
    logic                last_row;
    logic                col_nz;
    logic                last_col;
    logic                last_plane;
  } job_t;

  typedef struct packed {
    sample_t               value;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic                  run_last;
    logic                  plane_end;
    logic                  frame_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bilinear_upsample_2x.sv =====
// Top level of the 2x bilinear upsampler: APB registers, front end, job queue, output engine.
// A sample is registered in the front-end stage, then the job queue, then the result buffer.
// Each interior sample gives 4 results and an edge sample up to 9.
// The output engine sets the sustained rate: one result per cycle while its buffer has room.
// Reset clears counters and queues and sets all registers to 1; the line store is not cleared.
`default_nettype none

module bilinear_upsample_2x (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bu2x_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [bu2x_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [bu2x_pkg::APB_DATA_BITS-1:0]       prdata,
  output logic                                     pready,
  input  wire logic                                push,
  output logic                                     full,
  input  wire bu2x_pkg::sample_t                   sample,
  input  wire logic                                pop,
  output logic                                     empty,
  output bu2x_pkg::sample_t                        out_value,
  output logic [bu2x_pkg::COORD_BITS-1:0]          out_row,
  output logic [bu2x_pkg::COORD_BITS-1:0]          out_col,
  output logic                                     run_last,
  output logic                                     plane_end,
  output logic                                     frame_done
);

  logic [bu2x_pkg::DIM_BITS-1:0]   image_width;
  logic [bu2x_pkg::DIM_BITS-1:0]   image_height;
  logic [bu2x_pkg::PLANE_BITS-1:0] plane_count;
  logic [1:0]                      reg_index;
  logic                            reg_write;

  logic              front_valid;
  logic              front_ready;
  bu2x_pkg::job_t    front_job;
  logic              queue_valid;
  logic              queue_pop;
  bu2x_pkg::job_t    queue_job;
  bu2x_pkg::result_t result;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bu2x_pkg::DIM_BITS'(1);
      image_height <= bu2x_pkg::DIM_BITS'(1);
      plane_count  <= bu2x_pkg::PLANE_BITS'(1);
    end else if (reg_write) begin
      unique case (reg_index)
        bu2x_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[bu2x_pkg::DIM_BITS-1:0];
        bu2x_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[bu2x_pkg::DIM_BITS-1:0];
        bu2x_pkg::REG_PLANE_COUNT:  plane_count  <= pwdata[bu2x_pkg::PLANE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      bu2x_pkg::REG_IMAGE_WIDTH:  prdata = bu2x_pkg::APB_DATA_BITS'(image_width);
      bu2x_pkg::REG_IMAGE_HEIGHT: prdata = bu2x_pkg::APB_DATA_BITS'(image_height);
      bu2x_pkg::REG_PLANE_COUNT:  prdata = bu2x_pkg::APB_DATA_BITS'(plane_count);
      default:                    prdata = '0;
    endcase
  end

  bu2x_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .image_width  (image_width),
    .image_height (image_height),
    .plane_count  (plane_count),
    .job_valid    (front_valid),
    .job_ready    (front_ready),
    .job          (front_job)
  );

  bu2x_job_queue u_job_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_job    (front_job),
    .out_valid (queue_valid),
    .out_pop   (queue_pop),
    .out_job   (queue_job)
  );

  bu2x_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job       (queue_job),
    .job_pop   (queue_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign out_value  = result.value;
  assign out_row    = result.row;
  assign out_col    = result.col;
  assign run_last   = result.run_last;
  assign plane_end  = result.plane_end;
  assign frame_done = result.frame_done;

endmodule

`default_nettype wire

// ===== rtl/bu2x_front.sv =====
// Front end: accepts samples, tracks raster position, keeps the line store
// and the left neighbors, and hands one job per sample on. Uses bu2x_pkg.
`default_nettype none

module bu2x_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire bu2x_pkg::sample_t              sample,
  input  wire logic [bu2x_pkg::DIM_BITS-1:0]  image_width,
  input  wire logic [bu2x_pkg::DIM_BITS-1:0]  image_height,
  input  wire logic [bu2x_pkg::PLANE_BITS-1:0] plane_count,
  output logic                                job_valid,
  input  wire logic                           job_ready,
  output bu2x_pkg::job_t                      job
);

  bu2x_pkg::sample_t line_store [bu2x_pkg::MAX_WIDTH];
  bu2x_pkg::sample_t line_rdata;

  logic [bu2x_pkg::COL_BITS-1:0]   column_count;
  logic [bu2x_pkg::ROW_BITS-1:0]   row_count;
  logic [bu2x_pkg::PLANE_BITS-1:0] plane_counter;
  bu2x_pkg::sample_t               left_sample;
  bu2x_pkg::sample_t               upper_left_sample;

  logic                            stage_valid;
  bu2x_pkg::sample_t               stage_cur;
  logic [bu2x_pkg::ROW_BITS-1:0]   stage_row;
  logic [bu2x_pkg::COL_BITS-1:0]   stage_col;
  logic                            stage_last_row;
  logic                            stage_last_col;
  logic                            stage_last_plane;

  logic [bu2x_pkg::DIM_BITS-1:0]   width_lim;
  logic [bu2x_pkg::DIM_BITS-1:0]   height_lim;
  logic [bu2x_pkg::PLANE_BITS-1:0] planes_lim;
  logic                            last_col;
  logic                            last_row;
  logic                            last_plane;
  logic                            accept;
  logic                            fire;
  bu2x_pkg::sample_t               up;

  always_comb begin
    if (image_width == '0) begin
      width_lim = bu2x_pkg::DIM_BITS'(1);
    end else if (image_width > bu2x_pkg::DIM_BITS'(bu2x_pkg::MAX_WIDTH)) begin
      width_lim = bu2x_pkg::DIM_BITS'(bu2x_pkg::MAX_WIDTH);
    end else begin
      width_lim = image_width;
    end
    if (image_height == '0) begin
      height_lim = bu2x_pkg::DIM_BITS'(1);
    end else if (image_height > bu2x_pkg::DIM_BITS'(bu2x_pkg::MAX_HEIGHT)) begin
      height_lim = bu2x_pkg::DIM_BITS'(bu2x_pkg::MAX_HEIGHT);
    end else begin
      height_lim = image_height;
    end
    planes_lim = (plane_count == '0) ? bu2x_pkg::PLANE_BITS'(1) : plane_count;
  end

  assign last_col = (bu2x_pkg::DIM_BITS'(column_count) + bu2x_pkg::DIM_BITS'(1)) >= width_lim;
  assign last_row = (bu2x_pkg::DIM_BITS'(row_count) + bu2x_pkg::DIM_BITS'(1)) >= height_lim;
  assign last_plane = ({1'b0, plane_counter} + (bu2x_pkg::PLANE_BITS + 1)'(1))
                      >= {1'b0, planes_lim};

  assign fire   = stage_valid && job_ready;
  assign full   = stage_valid && !job_ready;
  assign accept = push && !full;

  // The row above is only read once it has been written in the same plane.
  assign up = (stage_row != '0) ? line_rdata : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      line_rdata              <= line_store[column_count];
      line_store[column_count] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= '0;
      row_count         <= '0;
      plane_counter     <= '0;
      left_sample       <= '0;
      upper_left_sample <= '0;
      stage_valid       <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
        if (last_col) begin
          column_count <= '0;
          if (last_row) begin
            row_count     <= '0;
            plane_counter <= last_plane ? '0 : plane_counter + bu2x_pkg::PLANE_BITS'(1);
          end else begin
            row_count <= row_count + bu2x_pkg::ROW_BITS'(1);
          end
        end else begin
          column_count <= column_count + bu2x_pkg::COL_BITS'(1);
        end
      end else if (fire) begin
        stage_valid <= 1'b0;
      end
      if (fire) begin
        left_sample       <= stage_cur;
        upper_left_sample <= up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cur        <= sample;
      stage_row        <= row_count;
      stage_col        <= column_count;
      stage_last_row   <= last_row;
      stage_last_col   <= last_col;
      stage_last_plane <= last_plane;
    end
  end

  assign job_valid = stage_valid;

  always_comb begin
    job.cur        = stage_cur;
    job.left       = left_sample;
    job.up         = up;
    job.up_left    = upper_left_sample;
    job.row        = stage_row;
    job.col        = stage_col;
    job.row_nz     = (stage_row != '0);
    job.last_row   = stage_last_row;
    job.col_nz     = (stage_col != '0);
    job.last_col   = stage_last_col;
    job.last_plane = stage_last_plane;
  end

endmodule

`default_nettype wire

// ===== rtl/bu2x_job_queue.sv =====
// Short queue of jobs between the front end and the output engine.
// Uses the job type from bu2x_pkg.
`default_nettype none

module bu2x_job_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bu2x_pkg::job_t in_job,
  output logic                out_valid,
  input  wire logic           out_pop,
  output bu2x_pkg::job_t      out_job
);

  bu2x_pkg::job_t                     entries [bu2x_pkg::JOBQ_DEPTH];
  logic [bu2x_pkg::JOBQ_PTR_BITS-1:0] wr_ptr;
  logic [bu2x_pkg::JOBQ_PTR_BITS-1:0] rd_ptr;
  logic [bu2x_pkg::JOBQ_PTR_BITS:0]   count;
  logic                               do_write;
  logic                               do_read;

  assign in_ready  = (count != (bu2x_pkg::JOBQ_PTR_BITS + 1)'(bu2x_pkg::JOBQ_DEPTH));
  assign out_valid = (count != '0);
  assign out_job   = entries[rd_ptr];
  assign do_write  = in_valid && in_ready;
  assign do_read   = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (do_write) begin
      entries[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= wr_ptr + bu2x_pkg::JOBQ_PTR_BITS'(1);
      end
      if (do_read) begin
        rd_ptr <= rd_ptr + bu2x_pkg::JOBQ_PTR_BITS'(1);
      end
      if (do_write && !do_read) begin
        count <= count + (bu2x_pkg::JOBQ_PTR_BITS + 1)'(1);
      end else if (do_read && !do_write) begin
        count <= count - (bu2x_pkg::JOBQ_PTR_BITS + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bu2x_back.sv =====
// Output engine: walks the output rows and columns of each job, blends the
// 2x2 window and buffers results in a two-entry queue. Uses bu2x_pkg.
`default_nettype none

module bu2x_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire bu2x_pkg::job_t job,
  output logic                job_pop,
  input  wire logic           pop,
  output logic                empty,
  output bu2x_pkg::result_t   result
);

  logic [1:0]        row_off;
  logic [1:0]        col_off;
  logic [1:0]        row_phase;
  logic [1:0]        col_phase;
  logic              row_done;
  logic              col_done;
  logic              row_near_cur;
  logic              row_far_cur;
  logic              col_near_cur;
  logic              col_far_cur;
  logic              emit;
  bu2x_pkg::sample_t a;
  bu2x_pkg::sample_t b;
  bu2x_pkg::sample_t c;
  bu2x_pkg::sample_t d;
  logic signed [bu2x_pkg::SUM_BITS-1:0] ax;
  logic signed [bu2x_pkg::SUM_BITS-1:0] bx;
  logic signed [bu2x_pkg::SUM_BITS-1:0] cx;
  logic signed [bu2x_pkg::SUM_BITS-1:0] dx;
  logic signed [bu2x_pkg::SUM_BITS-1:0] sum;
  bu2x_pkg::result_t new_result;

  bu2x_pkg::result_t obuf [2];
  logic              owr;
  logic              ord;
  logic [1:0]        ocount;
  logic              do_pop;

  function automatic bu2x_pkg::sample_t pick(input bu2x_pkg::job_t j, input logic row_cur,
                                             input logic col_cur);
    bu2x_pkg::sample_t v;
    unique case ({row_cur, col_cur})
      2'b11:   v = j.cur;
      2'b10:   v = j.left;
      2'b01:   v = j.up;
      default: v = j.up_left;
    endcase
    return v;
  endfunction

  assign row_phase = row_off + (job.row_nz ? bu2x_pkg::PHASE_BEFORE : bu2x_pkg::PHASE_AT);
  assign col_phase = col_off + (job.col_nz ? bu2x_pkg::PHASE_BEFORE : bu2x_pkg::PHASE_AT);
  assign row_done  = row_phase == (job.last_row ? bu2x_pkg::PHASE_AFTER : bu2x_pkg::PHASE_AT);
  assign col_done  = col_phase == (job.last_col ? bu2x_pkg::PHASE_AFTER : bu2x_pkg::PHASE_AT);

  assign row_near_cur = (row_phase != bu2x_pkg::PHASE_BEFORE);
  assign row_far_cur  = (row_phase != bu2x_pkg::PHASE_AT) || !job.row_nz;
  assign col_near_cur = (col_phase != bu2x_pkg::PHASE_BEFORE);
  assign col_far_cur  = (col_phase != bu2x_pkg::PHASE_AT) || !job.col_nz;

  assign a = pick(job, row_near_cur, col_near_cur);
  assign b = pick(job, row_near_cur, col_far_cur);
  assign c = pick(job, row_far_cur, col_near_cur);
  assign d = pick(job, row_far_cur, col_far_cur);

  assign ax  = bu2x_pkg::SUM_BITS'(a);
  assign bx  = bu2x_pkg::SUM_BITS'(b);
  assign cx  = bu2x_pkg::SUM_BITS'(c);
  assign dx  = bu2x_pkg::SUM_BITS'(d);
  assign sum = (ax <<< 3) + ax + (bx <<< 1) + bx + (cx <<< 1) + cx + dx
               + bu2x_pkg::SUM_BITS'(8);

  always_comb begin
    new_result.value      = sum[bu2x_pkg::SAMPLE_BITS+3:4];
    new_result.row        = {job.row, 1'b0} + bu2x_pkg::COORD_BITS'(row_phase)
                            - bu2x_pkg::COORD_BITS'(1);
    new_result.col        = {job.col, 1'b0} + bu2x_pkg::COORD_BITS'(col_phase)
                            - bu2x_pkg::COORD_BITS'(1);
    new_result.run_last   = row_done && col_done;
    new_result.plane_end  = row_done && col_done && job.last_row && job.last_col;
    new_result.frame_done = row_done && col_done && job.last_row && job.last_col
                            && job.last_plane;
  end

  assign emit    = job_valid && (ocount != 2'd2);
  assign job_pop = emit && row_done && col_done;
  assign do_pop  = pop && (ocount != 2'd0);
  assign empty   = (ocount == 2'd0);
  assign result  = obuf[ord];

  always_ff @(posedge clk) begin
    if (emit) begin
      obuf[owr] <= new_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_off <= '0;
      col_off <= '0;
      owr     <= 1'b0;
      ord     <= 1'b0;
      ocount  <= '0;
    end else begin
      if (emit) begin
        owr <= !owr;
        if (col_done) begin
          col_off <= '0;
          row_off <= row_done ? 2'd0 : row_off + 2'd1;
        end else begin
          col_off <= col_off + 2'd1;
        end
      end
      if (do_pop) begin
        ord <= !ord;
      end
      if (emit && !do_pop) begin
        ocount <= ocount + 2'd1;
      end else if (do_pop && !emit) begin
        ocount <= ocount - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire
